FILE: design/aed_pkg.sv
// Shared constants for the audio envelope detector: widths, register indexes and modes.
package aed_pkg;

  localparam int SampleWidth = 16;
  localparam int LevelWidth  = 31;
  localparam int CoefWidth   = 16;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 16;
  localparam int ProdWidth   = 48;

  // One in Q0.16, as a 17-bit constant used for the complementary coefficient.
  localparam logic [CoefWidth:0] ONE_Q16 = 17'h10000;

  // Largest legal level, 1.0 in Q1.30.
  localparam logic [LevelWidth-1:0] LEVEL_ONE = 31'h4000_0000;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_RELEASE = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_DETECT  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_BRANCH  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_SMOOTH  = 3'd4;

  // Detection modes.
  localparam logic [1:0] MODE_PEAK = 2'd0;
  localparam logic [1:0] MODE_MS   = 2'd1;
  localparam logic [1:0] MODE_RMS  = 2'd2;
  localparam logic [1:0] MODE_PRE  = 2'd3;

endpackage

FILE: design/audio_envelope_detector.sv
// Audio envelope follower with attack and release smoothing on one shared multiplier.
//
// Usage. Samples arrive on the input channel (in_valid, in_ready, sample) as signed
// Q1.15 values; one envelope value in unsigned Q1.30 leaves on the output channel
// (out_valid, out_ready, envelope_out) for each sample. Registers are written on the
// configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data), which is always
// ready; they should only be written while no request is in flight. Writing the
// branching mode register clears the envelope and the peak estimate.
//
// Sequencing. A sample is taken while the sequencer is idle and then worked on by a
// small sequencer that drives a single 17 x 31 bit multiplier: each smoother step runs
// through the states M1, M2 and SUM, and the decoupled mode runs two of them. The
// squaring modes add the states SQ and LDX, and the RMS mode adds a bit-pair square
// root. The result is written to the output register from the FIN state, and in_ready
// stays low meanwhile. The next request is taken only after that write, so the block
// does not take a new sample before it is through with the last one.
//
// The result sits in an output register. If the receiver stalls, the block still takes
// and works on the next request, and only waits before writing its result while the
// previous one has not been taken. Reset clears the configuration, the filter state,
// the sequencer and out_valid.
module audio_envelope_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [aed_pkg::SampleWidth-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [aed_pkg::LevelWidth-1:0]  envelope_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [aed_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic        [aed_pkg::CfgDataWidth-1:0] cfg_data
);

  localparam int LW = aed_pkg::LevelWidth;
  localparam int CW = aed_pkg::CoefWidth;
  localparam int PW = aed_pkg::ProdWidth;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_LDX  = 3'd2;
  localparam logic [2:0] ST_M1   = 3'd3;
  localparam logic [2:0] ST_M2   = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_SQRT = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  // Configuration registers.
  logic [CW-1:0] attack_coef;
  logic [CW-1:0] release_coef;
  logic [1:0]    detection_mode;
  logic          branching_mode;
  logic          smooth_release;

  // Filter state.
  logic [LW-1:0] envelope_level;
  logic [LW-1:0] fast_peak;

  // Sequencer and working registers.
  logic [2:0]    state;
  logic          phase;
  logic [15:0]   mag;
  logic [LW-1:0] x;
  logic [PW-1:0] prod;
  logic [31:0]   acc;
  logic [LW-1:0] result;

  // Square root working registers.
  logic [LW-1:0] sq_rem;
  logic [31:0]   sq_res;
  logic [LW-1:0] sq_bit;
  logic [3:0]    sq_cnt;

  logic          in_take;
  logic          cfg_take;
  logic          out_free;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;

  // Front end: magnitude, most negative sample giving exactly 2^15; MODE_PRE clamps at 0.
  logic        neg;
  logic [15:0] mag_in;
  logic [LW-1:0] x_direct;

  always_comb begin
    neg    = sample[aed_pkg::SampleWidth-1];
    mag_in = neg ? (16'd0 - 16'(sample)) : 16'(sample);
    if (detection_mode == aed_pkg::MODE_PRE) begin
      x_direct = neg ? '0 : {16'(sample), 15'd0};
    end else begin
      x_direct = {mag_in, 15'd0};
    end
  end

  // Operand selection for the shared multiplier. The attack path is taken in the
  // second pass of the decoupled mode, or in branching mode when the detector value
  // rises above the envelope.
  logic          use_attack;
  logic          use_second;
  logic [CW:0]   coef_a;
  logic [CW:0]   coef_r;
  logic [CW:0]   c1;
  logic [CW:0]   c2;
  logic [LW-1:0] v1;
  logic [LW-1:0] v2;
  logic [CW:0]   mul_a;
  logic [LW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  always_comb begin
    use_attack = branching_mode ? (x > envelope_level) : phase;
    use_second = use_attack || smooth_release;
    coef_a     = {1'b0, attack_coef};
    coef_r     = {1'b0, release_coef};
    c1         = use_attack ? coef_a : coef_r;
    c2         = aed_pkg::ONE_Q16 - c1;
    v1         = (!branching_mode && !phase) ? fast_peak : envelope_level;
    v2         = (!branching_mode && phase) ? fast_peak : x;
    unique case (state)
      ST_SQ: begin
        mul_a = {1'b0, mag};
        mul_b = {15'd0, mag};
      end
      ST_M1: begin
        mul_a = c1;
        mul_b = v1;
      end
      default: begin
        mul_a = c2;
        mul_b = v2;
      end
    endcase
    mul_p = {31'd0, mul_a} * {17'd0, mul_b};
  end

  // Truncated product sum (second term only if use_second), and the decoupled peak update.
  logic [31:0]   sum;
  logic [LW-1:0] peak_next;

  always_comb begin
    sum = acc + (use_second ? prod[PW-1:16] : 32'd0);
    peak_next = ({1'b0, x} > sum) ? x : sum[LW-1:0];
  end

  // One step of the bit-pair square root.
  logic [31:0]   sq_trial;
  logic          sq_fit;
  logic [LW-1:0] sq_rem_next;
  logic [31:0]   sq_res_next;

  always_comb begin
    sq_trial = sq_res + {1'b0, sq_bit};
    sq_fit   = ({1'b0, sq_rem} >= sq_trial);
    if (sq_fit) begin
      sq_rem_next = sq_rem - sq_trial[LW-1:0];
      sq_res_next = (sq_res >> 1) + {1'b0, sq_bit};
    end else begin
      sq_rem_next = sq_rem;
      sq_res_next = sq_res >> 1;
    end
  end

  // Configuration registers and the filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coef    <= '0;
      release_coef   <= '0;
      detection_mode <= aed_pkg::MODE_PEAK;
      branching_mode <= 1'b0;
      smooth_release <= 1'b0;
      envelope_level <= '0;
      fast_peak      <= '0;
    end else if (cfg_take) begin
      unique case (cfg_index)
        aed_pkg::REG_ATTACK:  attack_coef    <= cfg_data;
        aed_pkg::REG_RELEASE: release_coef   <= cfg_data;
        aed_pkg::REG_DETECT:  detection_mode <= cfg_data[1:0];
        aed_pkg::REG_BRANCH: begin
          branching_mode <= cfg_data[0];
          envelope_level <= '0;
          fast_peak      <= '0;
        end
        aed_pkg::REG_SMOOTH:  smooth_release <= cfg_data[0];
        default: ;
      endcase
    end else if (state == ST_SUM) begin
      if (!branching_mode && !phase) begin
        fast_peak <= peak_next;
      end else begin
        envelope_level <= sum[LW-1:0];
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            phase <= 1'b0;
            if (detection_mode == aed_pkg::MODE_MS || detection_mode == aed_pkg::MODE_RMS) begin
              state <= ST_SQ;
            end else begin
              state <= ST_M1;
            end
          end
        end
        ST_SQ:  state <= ST_LDX;
        ST_LDX: state <= ST_M1;
        ST_M1:  state <= ST_M2;
        ST_M2:  state <= ST_SUM;
        ST_SUM: begin
          if (!branching_mode && !phase) begin
            phase <= 1'b1;
            state <= ST_M1;
          end else if (detection_mode == aed_pkg::MODE_RMS) begin
            state <= ST_SQRT;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_SQRT: begin
          if (sq_cnt == 4'd15) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (in_take) begin
      mag <= mag_in;
      x   <= x_direct;
    end
    if (state == ST_LDX) begin
      x <= prod[LW-1:0];
    end
    if (state == ST_M2) begin
      acc <= prod[PW-1:16];
    end
    if (state == ST_SUM) begin
      result <= sum[LW-1:0];
      sq_rem <= sum[LW-1:0];
      sq_res <= '0;
      sq_bit <= aed_pkg::LEVEL_ONE;
      sq_cnt <= '0;
    end
    if (state == ST_SQRT) begin
      sq_rem <= sq_rem_next;
      sq_res <= sq_res_next;
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt + 4'd1;
      if (sq_cnt == 4'd15) begin
        result <= {sq_res_next[15:0], 15'd0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      envelope_out <= result;
    end
  end

  // Checks on the filter state and the sequencer.
  a_env_range: assert property (@(posedge clk) disable iff (rst)
    envelope_level <= aed_pkg::LEVEL_ONE)
    else $error("envelope level above one");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    fast_peak <= aed_pkg::LEVEL_ONE)
    else $error("peak estimate above one");

  a_branch_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_take && cfg_index == aed_pkg::REG_BRANCH |=> envelope_level == '0 && fast_peak == '0)
    else $error("branching mode write did not clear the state");

  a_second_pass: assert property (@(posedge clk) disable iff (rst)
    state == ST_M1 && phase |-> !branching_mode)
    else $error("second smoother pass in branching mode");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ready)
    else $error("request accepted while busy");

endmodule
